@@ src/fdcr_pkg.sv @@
// shared constants and types for the framed display command receiver
package fdcr_pkg;

	localparam int MAX_FRAME_DEF = 20;

	// frame bytes that carry fields; entries past the last one are never read
	localparam int FIELD_LAST = 8;

	localparam logic [7:0] HDR_BYTE  = 8'h43;
	localparam logic [7:0] TAIL_BYTE = 8'h54;
	localparam logic [7:0] CMD_CLEAR = 8'h41;
	localparam logic [7:0] CMD_FG    = 8'h42;
	localparam logic [7:0] CMD_BG    = 8'h43;
	localparam logic [7:0] CMD_EN    = 8'h44;
	localparam logic [7:0] CMD_CN    = 8'h45;

	localparam logic [2:0] KIND_CLEAR = 3'd0;
	localparam logic [2:0] KIND_FG    = 3'd1;
	localparam logic [2:0] KIND_BG    = 3'd2;
	localparam logic [2:0] KIND_EN    = 3'd3;
	localparam logic [2:0] KIND_CN    = 3'd4;

	typedef struct packed {
		logic [2:0]  command_kind;
		logic [15:0] color_word;
		logic [15:0] pos_x;
		logic [15:0] pos_y;
		logic [15:0] glyph_code;
		logic [15:0] fg_color;
		logic [15:0] bg_color;
	} fdcr_res_t;

endpackage

@@ src/framed_display_command_receiver.sv @@
// top level of the framed display command receiver
//
//  channel  direction  handshake             payload
//  in       to block   in_valid / in_stall   rx_data
//  out      from block out_valid / out_stall command_kind, color_word, pos_x,
//                                            pos_y, glyph_code, fg_color, bg_color
//
// one word accepted every cycle unless in_stall holds it; the closing tail word reaches
// the output through the input register, then the result register
// frame decode and colour update sit in one combinational pass between them
// reset clears the frame bytes, count and both colours, no sweep needed
// a stalled result holds the input register, words behind it wait at in_stall
module framed_display_command_receiver #(
	parameter int MAX_FRAME = fdcr_pkg::MAX_FRAME_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  rx_data,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  command_kind,
	output logic [15:0] color_word,
	output logic [15:0] pos_x,
	output logic [15:0] pos_y,
	output logic [15:0] glyph_code,
	output logic [15:0] fg_color,
	output logic [15:0] bg_color
);
	import fdcr_pkg::*;

	logic       advance;
	logic       valid_s1;
	logic [7:0] data_s1;
	logic       res_valid;
	fdcr_res_t  res;
	fdcr_res_t  res_q;

	fdcr_in_reg u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.rx_data  (rx_data),
		.advance  (advance),
		.in_stall (in_stall),
		.valid_s1 (valid_s1),
		.data_s1  (data_s1)
	);

	fdcr_frame #(
		.MAX_FRAME (MAX_FRAME)
	) u_frame (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (valid_s1 && advance),
		.data_s1   (data_s1),
		.res_valid (res_valid),
		.res       (res)
	);

	fdcr_out_reg u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.res_valid (res_valid),
		.res       (res),
		.out_stall (out_stall),
		.advance   (advance),
		.out_valid (out_valid),
		.res_q     (res_q)
	);

	assign command_kind = res_q.command_kind;
	assign color_word   = res_q.color_word;
	assign pos_x        = res_q.pos_x;
	assign pos_y        = res_q.pos_y;
	assign glyph_code   = res_q.glyph_code;
	assign fg_color     = res_q.fg_color;
	assign bg_color     = res_q.bg_color;

endmodule

@@ src/fdcr_in_reg.sv @@
// input register stage holding one received byte
module fdcr_in_reg (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic [7:0] rx_data,
	input  logic       advance,
	output logic       in_stall,
	output logic       valid_s1,
	output logic [7:0] data_s1
);

	// hold only when a byte is waiting and the next stage cannot move
	assign in_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			data_s1 <= rx_data;
		end
	end

endmodule

@@ src/fdcr_frame.sv @@
// frame assembly, tail check, command decode and colour state
module fdcr_frame #(
	parameter int MAX_FRAME = fdcr_pkg::MAX_FRAME_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                step,
	input  logic [7:0]          data_s1,
	output logic                res_valid,
	output fdcr_pkg::fdcr_res_t res
);
	import fdcr_pkg::*;

	localparam int CW = $clog2(MAX_FRAME + 1);
	localparam int LW = (CW > 8) ? CW : 8;
	localparam logic [CW-1:0] MAX_CNT = CW'(MAX_FRAME);

	logic [CW-1:0] cnt_q;
	logic [7:0]    fs_q [1:FIELD_LAST];
	logic [15:0]   fore_q;
	logic [15:0]   back_q;

	logic [CW-1:0] cnt_inc;
	logic [7:0]    nxt [1:FIELD_LAST];
	logic [7:0]    len;
	logic          hunting;
	logic          reach;
	logic          accept;
	logic          drop;
	logic          known;
	logic [15:0]   w3;
	logic [15:0]   w5;
	logic [15:0]   w7;

	assign hunting = (cnt_q == '0);
	assign cnt_inc = cnt_q + CW'(1);

	// length byte may be the one arriving now
	assign len   = (cnt_q == CW'(1)) ? data_s1 : fs_q[1];
	assign reach = (LW'(cnt_inc) >= LW'(len));

	assign accept = !hunting && reach && (data_s1 == TAIL_BYTE);
	assign drop   = !hunting && ((reach && (data_s1 != TAIL_BYTE)) ||
		(!reach && (cnt_inc == MAX_CNT)));

	always_comb begin
		for (int i = 1; i <= FIELD_LAST; i++) begin
			nxt[i] = (!hunting && (cnt_q == CW'(i))) ? data_s1 : fs_q[i];
		end
	end

	assign w3 = {nxt[4], nxt[3]};
	assign w5 = {nxt[6], nxt[5]};
	assign w7 = {nxt[8], nxt[7]};

	always_comb begin
		known            = 1'b1;
		res.command_kind = KIND_CLEAR;
		res.color_word   = '0;
		res.pos_x        = '0;
		res.pos_y        = '0;
		res.glyph_code   = '0;
		res.fg_color     = fore_q;
		res.bg_color     = back_q;
		case (nxt[2])
			CMD_CLEAR: begin
				res.color_word = w3;
			end
			CMD_FG: begin
				res.command_kind = KIND_FG;
				res.color_word   = w3;
				res.fg_color     = w3;
			end
			CMD_BG: begin
				res.command_kind = KIND_BG;
				res.color_word   = w3;
				res.bg_color     = w3;
			end
			CMD_EN: begin
				res.command_kind = KIND_EN;
				res.pos_x        = w3;
				res.pos_y        = w5;
				res.glyph_code   = {8'h00, nxt[7]};
			end
			CMD_CN: begin
				res.command_kind = KIND_CN;
				res.pos_x        = w3;
				res.pos_y        = w5;
				res.glyph_code   = w7;
			end
			default: begin
				known = 1'b0;
			end
		endcase
	end

	assign res_valid = step && accept && known;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			fore_q <= '0;
			back_q <= '0;
			for (int i = 1; i <= FIELD_LAST; i++) begin
				fs_q[i] <= '0;
			end
		end else if (step) begin
			if (hunting) begin
				if (data_s1 == HDR_BYTE) begin
					cnt_q <= CW'(1);
				end
			end else if (drop) begin
				cnt_q <= '0;
				for (int i = 1; i <= FIELD_LAST; i++) begin
					fs_q[i] <= '0;
				end
			end else begin
				cnt_q <= accept ? '0 : cnt_inc;
				for (int i = 1; i <= FIELD_LAST; i++) begin
					fs_q[i] <= nxt[i];
				end
				if (res_valid) begin
					fore_q <= res.fg_color;
					back_q <= res.bg_color;
				end
			end
		end
	end

endmodule

@@ src/fdcr_out_reg.sv @@
// result register toward the consumer
module fdcr_out_reg (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                res_valid,
	input  fdcr_pkg::fdcr_res_t res,
	input  logic                out_stall,
	output logic                advance,
	output logic                out_valid,
	output fdcr_pkg::fdcr_res_t res_q
);

	assign advance = !out_valid || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (advance) begin
			out_valid <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res_valid) begin
			res_q <= res;
		end
	end

endmodule

@@ src/fdcr_checker.sv @@
// port-level checks for the framed display command receiver, with bind
module fdcr_props (
	input logic        clk,
	input logic        arst_n,
	input logic        in_stall,
	input logic        out_valid,
	input logic        out_stall,
	input logic [2:0]  command_kind,
	input logic [15:0] color_word,
	input logic [15:0] pos_x,
	input logic [15:0] pos_y,
	input logic [15:0] glyph_code,
	input logic [15:0] fg_color,
	input logic [15:0] bg_color
);
	import fdcr_pkg::*;

	// input side only backs up behind a stalled result
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("in_stall without a stalled result");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result dropped while stalled");

	a_colour_kinds: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (command_kind == KIND_CLEAR || command_kind == KIND_FG ||
		command_kind == KIND_BG) |-> pos_x == '0 && pos_y == '0 && glyph_code == '0)
		else $error("colour command carries draw fields");

	a_fg_follow: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && command_kind == KIND_FG |-> fg_color == color_word)
		else $error("foreground not updated by its own command");

	a_bg_follow: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && command_kind == KIND_BG |-> bg_color == color_word)
		else $error("background not updated by its own command");

endmodule

bind framed_display_command_receiver fdcr_props u_fdcr_props (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_stall     (in_stall),
	.out_valid    (out_valid),
	.out_stall    (out_stall),
	.command_kind (command_kind),
	.color_word   (color_word),
	.pos_x        (pos_x),
	.pos_y        (pos_y),
	.glyph_code   (glyph_code),
	.fg_color     (fg_color),
	.bg_color     (bg_color)
);

@@ sim/fdcr_checker.sv @@
// checker for the framed display command receiver: predicts decoded commands and compares results
`timescale 1ns / 100ps
module fdcr_checker #(
	parameter int MAX_FRAME = fdcr_pkg::MAX_FRAME_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_stall,
	input  logic [7:0]  rx_data,
	input  logic        out_valid,
	input  logic        out_stall,
	input  logic [2:0]  command_kind,
	input  logic [15:0] color_word,
	input  logic [15:0] pos_x,
	input  logic [15:0] pos_y,
	input  logic [15:0] glyph_code,
	input  logic [15:0] fg_color,
	input  logic [15:0] bg_color,
	output int          mismatch_count,
	output int          outstanding
);

	import fdcr_pkg::*;

	logic [7:0]  frame_bytes [MAX_FRAME];
	int unsigned byte_fill;
	logic [15:0] fg_shadow;
	logic [15:0] bg_shadow;
	fdcr_res_t   expected_cmds [$];
	fdcr_res_t   seen;
	fdcr_res_t   want;
	int          misses = 0;

	task automatic clear_frame();
		for (int i = 0; i < MAX_FRAME; i++) begin
			frame_bytes[i] = 8'h00;
		end
		byte_fill = 0;
	endtask

	// one received word into the shadow frame, queues a decoded command when a frame with a known command closes
	task automatic absorb_word(input logic [7:0] b);
		fdcr_res_t r;
		r = '0;
		if (byte_fill == 0 || byte_fill >= MAX_FRAME) begin
			if (byte_fill != 0) begin
				clear_frame();
			end
			if (b == HDR_BYTE) begin
				frame_bytes[0] = b;
				byte_fill = 1;
			end
			return;
		end
		frame_bytes[byte_fill] = b;
		byte_fill++;
		if (byte_fill < frame_bytes[1]) begin
			// store full before the length is reached
			if (byte_fill >= MAX_FRAME) begin
				clear_frame();
			end
			return;
		end
		if (frame_bytes[byte_fill - 1] != TAIL_BYTE) begin
			clear_frame();
			return;
		end
		// good frame keeps the store, so short frames read stale bytes
		byte_fill = 0;
		case (frame_bytes[2])
			CMD_CLEAR: begin
				r.command_kind = KIND_CLEAR;
				r.color_word = {frame_bytes[4], frame_bytes[3]};
			end
			CMD_FG: begin
				r.command_kind = KIND_FG;
				r.color_word = {frame_bytes[4], frame_bytes[3]};
				fg_shadow = r.color_word;
			end
			CMD_BG: begin
				r.command_kind = KIND_BG;
				r.color_word = {frame_bytes[4], frame_bytes[3]};
				bg_shadow = r.color_word;
			end
			CMD_EN: begin
				r.command_kind = KIND_EN;
				r.pos_x = {frame_bytes[4], frame_bytes[3]};
				r.pos_y = {frame_bytes[6], frame_bytes[5]};
				r.glyph_code = {8'h00, frame_bytes[7]};
			end
			CMD_CN: begin
				r.command_kind = KIND_CN;
				r.pos_x = {frame_bytes[4], frame_bytes[3]};
				r.pos_y = {frame_bytes[6], frame_bytes[5]};
				r.glyph_code = {frame_bytes[8], frame_bytes[7]};
			end
			default: begin
				return;
			end
		endcase
		r.fg_color = fg_shadow;
		r.bg_color = bg_shadow;
		expected_cmds.push_back(r);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_frame();
			fg_shadow = 16'h0000;
			bg_shadow = 16'h0000;
			expected_cmds.delete();
		end else begin
			if (in_valid && !in_stall) begin
				absorb_word(rx_data);
			end
			if (out_valid && !out_stall) begin
				seen = {command_kind, color_word, pos_x, pos_y, glyph_code, fg_color, bg_color};
				if (expected_cmds.size() == 0) begin
					misses++;
					if (misses <= 10) begin
						$display("unexpected result: kind %0d color %h x %h y %h glyph %h fg %h bg %h",
							seen.command_kind, seen.color_word, seen.pos_x, seen.pos_y,
							seen.glyph_code, seen.fg_color, seen.bg_color);
					end
				end else begin
					want = expected_cmds.pop_front();
					if (seen !== want) begin
						misses++;
						if (misses <= 10) begin
							$display("expected kind %0d color %h x %h y %h glyph %h fg %h bg %h",
								want.command_kind, want.color_word, want.pos_x, want.pos_y,
								want.glyph_code, want.fg_color, want.bg_color);
							$display("     got kind %0d color %h x %h y %h glyph %h fg %h bg %h",
								seen.command_kind, seen.color_word, seen.pos_x, seen.pos_y,
								seen.glyph_code, seen.fg_color, seen.bg_color);
						end
					end
				end
			end
		end
		mismatch_count <= misses;
		outstanding <= expected_cmds.size();
	end

endmodule

@@ sim/tb_framed_display_command_receiver.sv @@
// testbench top for the framed display command receiver: frame stimulus, stalls and verdict
`timescale 1ns / 100ps
module tb_framed_display_command_receiver;

	import fdcr_pkg::*;

	localparam int MAX_FRAME = MAX_FRAME_DEF;
	localparam int IDLE_LIMIT = 2000;

	typedef enum {FILL_RAND, FILL_ZERO, FILL_ONES} fill_t;

	logic        clk;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [7:0]  rx_data = 8'h00;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [2:0]  command_kind;
	logic [15:0] color_word;
	logic [15:0] pos_x;
	logic [15:0] pos_y;
	logic [15:0] glyph_code;
	logic [15:0] fg_color;
	logic [15:0] bg_color;
	int          mismatch_count;
	int          outstanding;

	bit          calm = 1'b0;
	int          words_sent = 0;
	int          quiet_cycles = 0;

	framed_display_command_receiver u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.rx_data      (rx_data),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.command_kind (command_kind),
		.color_word   (color_word),
		.pos_x        (pos_x),
		.pos_y        (pos_y),
		.glyph_code   (glyph_code),
		.fg_color     (fg_color),
		.bg_color     (bg_color)
	);

	fdcr_checker u_check (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.rx_data        (rx_data),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.command_kind   (command_kind),
		.color_word     (color_word),
		.pos_x          (pos_x),
		.pos_y          (pos_y),
		.glyph_code     (glyph_code),
		.fg_color       (fg_color),
		.bg_color       (bg_color),
		.mismatch_count (mismatch_count),
		.outstanding    (outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	always @(posedge clk) begin
		out_stall <= !calm && ($urandom_range(99) < 38);
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
		if (quiet_cycles >= IDLE_LIMIT) begin
			$display("framed_display_command_receiver: mismatch");
			$finish;
		end
	end

	task automatic send_word(input logic [7:0] b);
		while (!calm && $urandom_range(99) < 38) begin
			in_valid <= 1'b0;
			rx_data <= 8'($urandom);
			@(posedge clk);
		end
		in_valid <= 1'b1;
		rx_data <= b;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		words_sent++;
	endtask

	// header, length, command, fields, tail; tiny lengths stop at the length word,
	// lengths past the store stop when it is full
	task automatic send_frame(input int len, input logic [7:0] cmd, input bit tail_ok,
		input fill_t fill);
		int n;
		logic [7:0] b;
		n = (len <= 2) ? 2 : ((len > MAX_FRAME) ? MAX_FRAME : len);
		for (int i = 0; i < n; i++) begin
			if (i == 0) begin
				b = HDR_BYTE;
			end else if (i == 1) begin
				b = len[7:0];
			end else if (i == n - 1 && len >= 3 && len <= MAX_FRAME) begin
				if (tail_ok) begin
					b = TAIL_BYTE;
				end else begin
					b = 8'($urandom);
					while (b == TAIL_BYTE) b = 8'($urandom);
				end
			end else if (i == 2) begin
				b = cmd;
			end else begin
				case (fill)
					FILL_ZERO: b = 8'h00;
					FILL_ONES: b = 8'hFF;
					default: b = 8'($urandom);
				endcase
			end
			send_word(b);
		end
	endtask

	initial begin
		int pick;
		int len;
		int natural;
		logic [7:0] cmd;
		logic [7:0] junk;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// words before any header are ignored
		send_word(8'h00);
		send_word(8'hFF);
		send_frame(6, CMD_CLEAR, 1'b1, FILL_ONES);
		send_frame(6, CMD_FG, 1'b1, FILL_ONES);
		send_frame(6, CMD_BG, 1'b1, FILL_ZERO);
		send_frame(9, CMD_EN, 1'b1, FILL_ONES);
		send_frame(10, CMD_CN, 1'b1, FILL_ZERO);
		send_frame(MAX_FRAME, CMD_CN, 1'b1, FILL_RAND);
		// short frame picks fields out of the previous one
		send_frame(4, CMD_EN, 1'b1, FILL_RAND);
		send_frame(6, CMD_FG, 1'b0, FILL_RAND);
		// after a bad tail the stale fields read as zero
		send_frame(5, CMD_CN, 1'b1, FILL_RAND);
		send_frame(0, CMD_CLEAR, 1'b1, FILL_RAND);
		send_frame(1, CMD_CLEAR, 1'b1, FILL_RAND);
		send_frame(2, CMD_CLEAR, 1'b1, FILL_RAND);
		send_frame(3, CMD_CLEAR, 1'b1, FILL_RAND);
		send_frame(8, 8'h46, 1'b1, FILL_RAND);
		send_frame(MAX_FRAME + 1, CMD_CLEAR, 1'b1, FILL_RAND);
		send_frame(255, CMD_BG, 1'b1, FILL_ONES);
		send_frame(6, CMD_BG, 1'b1, FILL_ONES);

		while (words_sent < 550) begin
			calm = (words_sent >= 250 && words_sent < 350);
			pick = $urandom_range(99);
			cmd = CMD_CLEAR + 8'($urandom_range(4));
			natural = (cmd == CMD_CN) ? 10 : ((cmd == CMD_EN) ? 9 : 6);
			if (pick < 70) begin
				len = ($urandom_range(3) == 0) ? $urandom_range(3, MAX_FRAME) : natural;
				send_frame(len, cmd, 1'b1, FILL_RAND);
			end else if (pick < 78) begin
				send_frame(natural, cmd, 1'b0, FILL_RAND);
			end else if (pick < 84) begin
				send_frame($urandom_range(3, MAX_FRAME), 8'($urandom), 1'b1, FILL_RAND);
			end else if (pick < 88) begin
				send_frame($urandom_range(MAX_FRAME + 1, 255), cmd, 1'b1, FILL_RAND);
			end else if (pick < 92) begin
				send_frame($urandom_range(2), cmd, 1'b1, FILL_RAND);
			end else begin
				// raw words, a header among them breaks the next frame
				repeat ($urandom_range(1, 4)) send_word(8'($urandom));
			end
			if ($urandom_range(3) == 0) begin
				junk = 8'($urandom);
				while (junk == HDR_BYTE) junk = 8'($urandom);
				send_word(junk);
			end
		end
		calm = 1'b0;
		in_valid <= 1'b0;

		while (outstanding != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		if (mismatch_count == 0 && outstanding == 0) begin
			$display("framed_display_command_receiver: match");
		end else begin
			$display("framed_display_command_receiver: mismatch");
		end
		$finish;
	end

endmodule

@@ files.f @@
src/fdcr_pkg.sv
src/fdcr_in_reg.sv
src/fdcr_frame.sv
src/fdcr_out_reg.sv
src/framed_display_command_receiver.sv
src/fdcr_checker.sv
sim/fdcr_checker.sv
sim/tb_framed_display_command_receiver.sv
